[rtl/pcd_pkg.sv]
// Shared types, constants and functions of the PNG chunk deframer.
package pcd_pkg;

    localparam int unsigned NUM_TYPES = 18;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

    // Public chunk types; the code of a type is its place in this list plus one.
    localparam logic [31:0] TYPE_NAMES [NUM_TYPES] = '{
        32'h49484452, 32'h504C5445, 32'h49444154, 32'h49454E44, 32'h74524E53,
        32'h67414D41, 32'h6348524D, 32'h73524742, 32'h69434350, 32'h74455874,
        32'h7A545874, 32'h69545874, 32'h624B4744, 32'h70485973, 32'h73424954,
        32'h73504C54, 32'h68495354, 32'h74494D45
    };

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_CRC  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_TRUNC = 2'd2
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [4:0]  type_code;
        logic [31:0] chunk_length;
        logic [31:0] received_crc;
        logic        crc_ok;
    } t_result;

    // One byte of the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [4:0] lookup_type(input logic [31:0] v);
        logic [4:0] code;
        code = '0;
        for (int i = 0; i < NUM_TYPES; i++) begin
            if (v == TYPE_NAMES[i]) begin
                code = 5'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

[rtl/pcd_if.sv]
// Stream interfaces of the PNG chunk deframer: input bytes and results.
interface pcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source(output valid, in_byte, end_of_stream, input ready);
    modport sink(input valid, in_byte, end_of_stream, output ready);
endinterface

interface pcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [4:0]  type_code;
    logic [31:0] chunk_length;
    logic [31:0] received_crc;
    logic        crc_ok;

    modport source(output valid, kind, payload_byte, type_code, chunk_length,
                   received_crc, crc_ok, input ready);
    modport sink(input valid, kind, payload_byte, type_code, chunk_length,
                 received_crc, crc_ok, output ready);
endinterface

[rtl/pcd_parser.sv]
// Chunk parser: phase state, field capture, running CRC and result formation.
module pcd_parser
    import pcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_eos,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type_bytes, n_type_bytes;
    logic [4:0]  r_type, n_type;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_field, n_field;

    logic [31:0] count_inc;
    logic        chunk_done;
    t_result     res;

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_len        = r_len;
        n_type_bytes = r_type_bytes;
        n_type       = r_type;
        n_crc        = r_crc;
        n_field      = r_field;
        count_inc    = r_count + 32'd1;
        chunk_done   = 1'b0;
        res          = '0;
        res.kind     = KIND_DATA;

        case (r_phase)
            PH_LEN: begin
                n_len   = {r_len[23:0], i_byte};
                n_count = count_inc;
                if (count_inc >= 32'd4) begin
                    n_phase = PH_TYPE;
                    n_count = '0;
                end
            end
            PH_TYPE: begin
                n_type_bytes = {r_type_bytes[23:0], i_byte};
                n_crc        = crc32_byte(r_crc, i_byte);
                n_count      = count_inc;
                if (count_inc >= 32'd4) begin
                    n_type  = lookup_type(n_type_bytes);
                    n_count = '0;
                    n_phase = (r_len == 32'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc   = crc32_byte(r_crc, i_byte);
                n_count = count_inc;
                if (!i_eos) begin
                    res.valid        = 1'b1;
                    res.kind         = KIND_DATA;
                    res.payload_byte = i_byte;
                    res.type_code    = r_type;
                    res.chunk_length = r_len;
                end
                if (count_inc >= r_len) begin
                    n_phase = PH_CRC;
                    n_count = '0;
                end
            end
            PH_CRC: begin
                n_field = {r_field[23:0], i_byte};
                n_count = count_inc;
                if (count_inc >= 32'd4) begin
                    // The final inversion of the CRC is folded into the compare.
                    chunk_done       = 1'b1;
                    res.valid        = 1'b1;
                    res.kind         = KIND_END;
                    res.type_code    = r_type;
                    res.chunk_length = r_len;
                    res.received_crc = n_field;
                    res.crc_ok       = ((r_crc ^ CRC_PRESET) == n_field);
                end
            end
            default: begin
                n_phase = PH_LEN;
            end
        endcase

        // End of stream anywhere but on the last CRC byte cuts the chunk short.
        if (i_eos && !chunk_done) begin
            res              = '0;
            res.valid        = 1'b1;
            res.kind         = KIND_TRUNC;
            res.type_code    = n_type;
            res.chunk_length = n_len;
            chunk_done       = 1'b1;
        end

        if (chunk_done) begin
            n_phase      = PH_LEN;
            n_count      = '0;
            n_len        = '0;
            n_type_bytes = '0;
            n_type       = '0;
            n_crc        = CRC_PRESET;
            n_field      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_count      <= '0;
            r_len        <= '0;
            r_type_bytes <= '0;
            r_type       <= '0;
            r_crc        <= CRC_PRESET;
            r_field      <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_len        <= n_len;
            r_type_bytes <= n_type_bytes;
            r_type       <= n_type;
            r_crc        <= n_crc;
            r_field      <= n_field;
        end
    end

    always_comb begin
        o_result       = res;
        o_result.valid = res.valid & i_accept;
    end

endmodule

[rtl/png_chunk_deframer_top.sv]
// Top level of the PNG chunk deframer: input handshake, parser and result register.
// The block takes one byte of a PNG chunk stream (signature removed) per cycle and gives
// at most one result per byte: each data byte with its chunk type code, a chunk-end
// result after the last CRC byte carrying the length, the received CRC and a CRC match
// flag, or a truncation result when end_of_stream arrives inside a chunk. The phase logic
// and the one-byte CRC-32 update sit between the parser state registers, and the result
// register is written in the same cycle the byte is accepted. The input stays ready while
// the result register is empty or being drained, so bytes stream at full rate whenever the
// sink takes results; an accepted byte's result is on the output in the cycle after.
module png_chunk_deframer_top
    import pcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcd_in_if.sink        i_in,
    pcd_out_if.source     o_out
);

    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    logic    in_accept;
    t_result parse_res;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    pcd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.in_byte),
        .i_eos    (i_in.end_of_stream),
        .o_result (parse_res)
    );

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (parse_res.valid) begin
            n_out       = parse_res;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.type_code    = r_out.type_code;
    assign o_out.chunk_length = r_out.chunk_length;
    assign o_out.received_crc = r_out.received_crc;
    assign o_out.crc_ok       = r_out.crc_ok;

    // A new result must never land on a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_res.valid |-> !(r_out_valid && !o_out.ready))
        else $error("result register overwritten while stalled");

    // Every result from the parser shows up on the output in the next cycle.
    a_result_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_res.valid |=> r_out_valid)
        else $error("parser result lost");

    // Data results never carry trailer fields.
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_DATA) |->
            (r_out.received_crc == 32'd0 && !r_out.crc_ok))
        else $error("data result with CRC fields set");

endmodule
